// File: rtl/bfp_pkg.sv
// ----------------------------------------------------------------------------
// bfp_pkg: shared constants and types for the two-probe Bloom filter
// Array geometry, operation codes, multiplier reset value and the request
// record that moves from the front end to the back end.
// ----------------------------------------------------------------------------
package bfp_pkg;

  // Filter size must stay a power of two: a position is then the low bits
  // of the product, and the second probe is the first one shifted left.
  localparam int SIZE   = 1024;
  localparam int IDX_W  = $clog2(SIZE);
  localparam int ROW_W  = 32;
  localparam int COL_W  = $clog2(ROW_W);
  localparam int ROWS   = SIZE / ROW_W;
  localparam int ROW_AW = $clog2(ROWS);

  localparam logic [1:0] OP_QUERY  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [31:0] MULT_RESET = 32'd31;

  typedef struct packed {
    logic             clear;
    logic             ins;
    logic [IDX_W-1:0] pos;
  } bfp_req_t;

endpackage

// File: rtl/bfp_front.sv
// ----------------------------------------------------------------------------
// bfp_front: request intake and hashing
// Holds the multiplier, classifies each request, computes its first probe
// position and parks it in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module bfp_front
  import bfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_key,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output bfp_req_t    req,
  output logic        req_vld,
  input  logic        req_pop
);

  // Only the low product bits reach a position, so keep only the low
  // multiplier bits.
  logic [IDX_W-1:0]   mult_r;
  logic [2*IDX_W-1:0] prod;
  bfp_req_t           new_req;

  bfp_req_t   q_r [2];
  logic [1:0] cnt_r;
  logic       wp_r;
  logic       rp_r;
  logic       push;
  logic       pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r <= MULT_RESET[IDX_W-1:0];
    end else if (cfg_we) begin
      mult_r <= cfg_wdata[IDX_W-1:0];
    end
  end

  assign prod          = mult_r * in_key[IDX_W-1:0];
  assign new_req.clear = (in_op == OP_CLEAR);
  assign new_req.ins   = (in_op == OP_INSERT);
  assign new_req.pos   = prod[IDX_W-1:0];

  assign in_full = (cnt_r == 2'd2);
  assign req_vld = (cnt_r != 2'd0);
  assign req     = q_r[rp_r];
  assign push    = in_push && !in_full;
  assign pop     = req_pop && req_vld;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= new_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// File: rtl/bfp_back.sv
// ----------------------------------------------------------------------------
// bfp_back: filter array and probe sequencer
// Keeps the bit array as rows with per-row valid bits, reads both probe rows,
// sets the bits on a missing insert and queues the answers.
// ----------------------------------------------------------------------------
module bfp_back
  import bfp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  bfp_req_t req,
  input  logic     req_vld,
  output logic     req_pop,
  output logic     out_empty,
  input  logic     out_pop,
  output logic     out_present
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROWS-1:0]  row_vld_r;

  logic [IDX_W-1:0] pos_b;
  logic             ins_r;
  logic [IDX_W-1:0] pa_r;
  logic [IDX_W-1:0] pb_r;
  logic [ROW_W-1:0] rd_a_r;
  logic [ROW_W-1:0] rd_b_r;
  logic [ROW_W-1:0] wr_b_r;

  logic [ROW_AW-1:0] row_a;
  logic [ROW_AW-1:0] row_b;
  logic [ROW_W-1:0]  eff_a;
  logic [ROW_W-1:0]  eff_b;
  logic [ROW_W-1:0]  bit_a;
  logic [ROW_W-1:0]  bit_b;
  logic [ROW_W-1:0]  new_a;
  logic [ROW_W-1:0]  new_b;
  logic              same_row;
  logic              hit;
  logic              take;
  logic              do_set;

  logic              wr_en;
  logic [ROW_AW-1:0] wr_row;
  logic [ROW_W-1:0]  wr_data;

  logic       res_q_r [2];
  logic [1:0] res_cnt_r;
  logic       res_wp_r;
  logic       res_rp_r;
  logic       res_push;
  logic       res_din;
  logic       res_pop;

  assign take    = (state_r == ST_IDLE) && req_vld && (res_cnt_r != 2'd2);
  assign req_pop = take;
  assign pos_b   = {req.pos[IDX_W-2:0], 1'b0};

  // Rows never written since the last clear read as zero.
  assign row_a    = pa_r[IDX_W-1:COL_W];
  assign row_b    = pb_r[IDX_W-1:COL_W];
  assign same_row = (row_a == row_b);
  assign eff_a    = row_vld_r[row_a] ? rd_a_r : '0;
  assign eff_b    = row_vld_r[row_b] ? rd_b_r : '0;
  assign bit_a    = ROW_W'(1) << pa_r[COL_W-1:0];
  assign bit_b    = ROW_W'(1) << pb_r[COL_W-1:0];
  assign hit      = eff_a[pa_r[COL_W-1:0]] && eff_b[pb_r[COL_W-1:0]];
  assign new_a    = eff_a | bit_a | (same_row ? bit_b : '0);
  assign new_b    = same_row ? new_a : (eff_b | bit_b);
  assign do_set   = (state_r == ST_LOOK) && ins_r && !hit;

  assign wr_en   = do_set || (state_r == ST_FIX);
  assign wr_row  = (state_r == ST_FIX) ? row_b : row_a;
  assign wr_data = (state_r == ST_FIX) ? wr_b_r : new_a;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take && !req.clear) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = do_set ? ST_FIX : ST_IDLE;
      end
      ST_FIX: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      row_vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (take && req.clear) begin
        row_vld_r <= '0;
      end else if (wr_en) begin
        row_vld_r[wr_row] <= 1'b1;
      end
    end
  end

  // Array: one write port, two registered read ports. Reads only issue in
  // idle, writes only in the look and fix steps.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    if (take) begin
      rd_a_r <= mem[req.pos[IDX_W-1:COL_W]];
      rd_b_r <= mem[pos_b[IDX_W-1:COL_W]];
      ins_r  <= req.ins;
      pa_r   <= req.pos;
      pb_r   <= pos_b;
    end
    if (do_set) begin
      wr_b_r <= new_b;
    end
  end

  // Result queue
  assign res_push    = (take && req.clear) || (state_r == ST_LOOK);
  assign res_din     = (state_r == ST_LOOK) && hit;
  assign out_empty   = (res_cnt_r == 2'd0);
  assign out_present = res_q_r[res_rp_r];
  assign res_pop     = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_q_r[res_wp_r] <= res_din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_cnt_r <= 2'd0;
      res_wp_r  <= 1'b0;
      res_rp_r  <= 1'b0;
    end else begin
      if (res_push) begin
        res_wp_r <= ~res_wp_r;
      end
      if (res_pop) begin
        res_rp_r <= ~res_rp_r;
      end
      if (res_push && !res_pop) begin
        res_cnt_r <= res_cnt_r + 2'd1;
      end else if (res_pop && !res_push) begin
        res_cnt_r <= res_cnt_r - 2'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r != 2'd3)
    else $error("result queue overflow");

  a_fix_after_look: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIX) |-> ($past(state_r) == ST_LOOK))
    else $error("fix step without a look step");

  a_clear_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (take && req.clear) |=> (row_vld_r == '0))
    else $error("clear left a valid row");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK) |-> ($past(res_cnt_r) != 2'd2))
    else $error("probe started without result space");
`endif

endmodule

// File: rtl/bloom_filter_two_probe_core.sv
// ----------------------------------------------------------------------------
// bloom_filter_two_probe_core: two-probe Bloom filter over 1024 bits
// Usage:
//   Requests enter through a queue-style port: drive in_op/in_key with
//   in_push; a request is taken on a clock edge with in_push high and
//   in_full low. op 0 queries, 1 inserts, 2 clears every bit; op 3 queries.
//   Answers leave through a queue-style port: out_present is valid while
//   out_empty is low and is taken on an edge with out_pop high.
//   cfg_we/cfg_wdata load the hash multiplier (reset 31) while idle.
// Sequencing:
//   With both queues empty, a query or insert writes its answer into the
//   answer queue from the look step, a clear in the cycle it is taken.
//   A query passes the idle and look steps of the probe sequencer, an insert
//   that sets bits also the fix step (two row writes through the single array
//   write port), a clear only idle. A two-entry request queue and a two-entry
//   answer queue sit on either side of the sequencer.
// Reset:
//   rst_n (synchronous) empties both queues and invalidates every array
//   row; no sweep is needed. If out_pop stays low the answer queue fills,
//   the sequencer holds, and in_full rises once the request queue is full.
// ----------------------------------------------------------------------------
module bloom_filter_two_probe_core
  import bfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_key,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_present,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  bfp_req_t req;
  logic     req_vld;
  logic     req_pop;

  bfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_op     (in_op),
    .in_key    (in_key),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .req_vld   (req_vld),
    .req_pop   (req_pop)
  );

  bfp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req),
    .req_vld     (req_vld),
    .req_pop     (req_pop),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_present (out_present)
  );

endmodule
